FILE: rtl/vcwh_pkg.sv
package vcwh_pkg;

  localparam int unsigned OFF_W  = 16;
  localparam int unsigned RNG_W  = 16;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned ERR_W  = 24;
  localparam int unsigned YAW_W  = 20;
  localparam int unsigned LIM_W  = 19;
  localparam int unsigned HOLD_W = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned MAG_W  = OFF_W + 1;

  // Products of a filter value and a Q16 coefficient, and the rounded result.
  localparam int unsigned PROD_W = 42;
  localparam int unsigned RND_W  = 26;
  localparam int unsigned Q_SHIFT = 16;

  typedef enum logic [1:0] {
    STATUS_RUN  = 2'd0,
    STATUS_OK   = 2'd1,
    STATUS_FAIL = 2'd2
  } vcwh_status_t;

  localparam logic [0:0] CFG_YAW_LIMIT = 1'b0;
  localparam logic [0:0] CFG_HOLD_TIME = 1'b1;

  localparam logic [LIM_W-1:0]  YAW_LIMIT_RST = 19'd32768;
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 20'd3000;

  localparam logic signed [17:0] COEF_KEEP = 18'sd39322;
  localparam logic signed [17:0] COEF_NEW  = 18'sd26214;
  localparam logic signed [17:0] COEF_GAIN = 18'sd52429;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 42'sd32768;

  localparam logic [RNG_W-1:0] MIN_DEN       = 16'd500;
  localparam logic [4:0]       CENTER_FACTOR = 5'd20;
  localparam logic [1:0]       CONFIRM_FRAMES = 2'd3;

  localparam logic signed [RND_W-1:0] ERR_POS = 26'sd8388607;
  localparam logic signed [RND_W-1:0] ERR_NEG = -26'sd8388608;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FILT_A,
    ST_FILT_B,
    ST_GAIN_A,
    ST_GAIN_B,
    ST_EMIT
  } vcwh_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic filt_a;
    logic filt_b;
    logic gain_a;
    logic gain_b;
    logic load_out;
  } vcwh_cmd_t;

  typedef struct packed {
    logic quick;
  } vcwh_sts_t;

endpackage

FILE: rtl/visual_center_with_hold.sv
// Begin, lost, holding and confirming frames go from the eval state straight to the emit state;
// a tracking frame first passes through the bit-serial divider (one quotient bit per cycle)
// and then four filter and gain steps. A beat is taken only in the idle state, so the block
// finishes one frame before it takes the next; the emit state waits for a free output slot.
// A new beat is taken while a finished result still waits on the output.
// Reset (synchronous, rst_n low) clears all tracking state and loads default limits.
module visual_center_with_hold
  import vcwh_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned LOST_LIMIT = 50
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic                    in_seen,
  input  logic signed [OFF_W-1:0] in_offset_mm,
  input  logic [RNG_W-1:0]        in_range_mm,
  input  logic [TS_W-1:0]         in_now_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic                    out_cmd_valid,
  output logic signed [YAW_W-1:0] out_yaw_cmd
);

  localparam int unsigned DIV_STEPS = MAG_W + FRAC_BITS;

  vcwh_cmd_t cmd;
  vcwh_sts_t sts;

  vcwh_ctrl #(
    .DIV_STEPS(DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vcwh_dp #(
    .FRAC_BITS (FRAC_BITS),
    .LOST_LIMIT(LOST_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_func      (in_func),
    .in_seen      (in_seen),
    .in_offset_mm (in_offset_mm),
    .in_range_mm  (in_range_mm),
    .in_now_ms    (in_now_ms),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_status),
    .out_cmd_valid(out_cmd_valid),
    .out_yaw_cmd  (out_yaw_cmd)
  );

`ifndef ASSERT_OFF
  // A beat without a command carries a zero yaw.
  a_no_cmd_zero_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_valid |-> out_yaw_cmd == '0)
    else $error("yaw nonzero without command");

  // Success is only reported while holding still.
  a_ok_holds_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_OK |-> out_cmd_valid && out_yaw_cmd == '0)
    else $error("success beat with nonzero yaw");

  // Failure only comes from the lost-target path, which always commands yaw.
  a_fail_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_FAIL |-> out_cmd_valid)
    else $error("failure beat without command");

  // The block works on one frame at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");
`endif

endmodule

FILE: rtl/vcwh_ctrl.sv
module vcwh_ctrl
  import vcwh_pkg::*;
#(
  parameter int unsigned DIV_STEPS = 33
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vcwh_sts_t sts,
  output vcwh_cmd_t cmd
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  vcwh_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          div_last;
  logic          slot_free;

  assign div_last  = (cnt_r == CW'(DIV_STEPS - 1));
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = sts.quick ? ST_EMIT : ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_FILT_A;
      ST_FILT_A: state_nxt = ST_FILT_B;
      ST_FILT_B: state_nxt = ST_GAIN_A;
      ST_GAIN_A: state_nxt = ST_GAIN_B;
      ST_GAIN_B: state_nxt = ST_EMIT;
      ST_EMIT:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cnt_nxt  = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      ST_FILT_A: cmd.filt_a = 1'b1;
      ST_FILT_B: cmd.filt_b = 1'b1;
      ST_GAIN_A: cmd.gain_a = 1'b1;
      ST_GAIN_B: cmd.gain_b = 1'b1;
      ST_EMIT:   cmd.load_out = slot_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/vcwh_dp.sv
module vcwh_dp
  import vcwh_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned LOST_LIMIT = 50
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_func,
  input  logic                    in_seen,
  input  logic signed [OFF_W-1:0] in_offset_mm,
  input  logic [RNG_W-1:0]        in_range_mm,
  input  logic [TS_W-1:0]         in_now_ms,
  input  vcwh_cmd_t               cmd,
  output vcwh_sts_t               sts,
  output logic [1:0]              out_status,
  output logic                    out_cmd_valid,
  output logic signed [YAW_W-1:0] out_yaw_cmd
);

  localparam int unsigned DW = MAG_W + FRAC_BITS;
  localparam int unsigned LW = $clog2(LOST_LIMIT + 2);

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] r;
    r = v;
    if (v > ERR_POS) r = ERR_POS;
    if (v < ERR_NEG) r = ERR_NEG;
    return r[ERR_W-1:0];
  endfunction

  function automatic logic signed [YAW_W-1:0] clamp_lim(input logic signed [RND_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [RND_W-1:0] lv;
    logic signed [RND_W-1:0] r;
    lv = $signed({{(RND_W - LIM_W){1'b0}}, lim});
    r  = v;
    if (v > lv) r = lv;
    if (v < -lv) r = -lv;
    return r[YAW_W-1:0];
  endfunction

  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = (v + ROUND_HALF) >>> Q_SHIFT;
    return t[RND_W-1:0];
  endfunction

  // Latched input beat.
  logic                    func_r, seen_r;
  logic signed [OFF_W-1:0] off_r;
  logic [RNG_W-1:0]        rng_r;
  logic [TS_W-1:0]         now_r;

  // Configuration.
  logic [LIM_W-1:0]  lim_r;
  logic [HOLD_W-1:0] hold_r;

  // Tracking state.
  logic signed [ERR_W-1:0] f_r, f_nxt;
  logic [1:0]              cc_r, cc_nxt;
  logic [LW-1:0]           lost_r, lost_nxt;
  logic                    holding_r, holding_nxt;
  logic [TS_W-1:0]         hs_r, hs_nxt;

  // Divider and filter pipeline.
  logic [RNG_W-1:0]          rem_r, rem_nxt;
  logic [DW-1:0]             qr_r, qr_nxt;
  logic signed [ERR_W:0]     neg_n_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r;

  // Result held until the output slot frees up.
  logic [1:0]              res_status_r, res_status_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic signed [YAW_W-1:0] res_yaw_r, res_yaw_nxt;

  logic [1:0]              out_status_r;
  logic                    out_cmd_valid_r;
  logic signed [YAW_W-1:0] out_yaw_cmd_r;

  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [RNG_W-1:0]        den;
  logic [21:0]             mag20;
  logic                    centred;
  logic [1:0]              cc_inc;
  logic                    confirm;
  logic [LW-1:0]           lost_inc;
  logic [TS_W-1:0]         elapsed;
  logic                    hold_done;
  logic signed [RND_W-1:0] lost_base;
  logic [RNG_W:0]          trial;
  logic                    ge;
  logic [DW-1:0]           qmax, qsat;
  logic signed [ERR_W:0]   neg_n_nxt;
  logic signed [PROD_W-1:0] acc;

  assign neg     = off_r[OFF_W-1];
  assign mag     = neg ? MAG_W'(-{off_r[OFF_W-1], off_r}) : MAG_W'({1'b0, off_r});
  assign den     = (rng_r > MIN_DEN) ? rng_r : MIN_DEN;
  assign mag20   = 22'(mag) * 22'(CENTER_FACTOR);
  assign centred = (mag20 < 22'(den));
  assign cc_inc  = (cc_r < CONFIRM_FRAMES) ? cc_r + 2'd1 : cc_r;
  assign confirm = centred && (cc_inc == CONFIRM_FRAMES);
  assign lost_inc  = (lost_r <= LW'(LOST_LIMIT)) ? lost_r + 1'b1 : lost_r;
  assign elapsed   = now_r - hs_r;
  assign hold_done = (elapsed >= TS_W'(hold_r));

  // With nothing filtered yet, a lost target is sought at half the yaw limit.
  assign lost_base = (f_r == '0) ? -$signed(RND_W'(lim_r >> 1)) : RND_W'(f_r);

  assign sts.quick = !func_r || !seen_r || holding_r || confirm;

  // One quotient bit per step of the restoring divider.
  assign trial   = {rem_r, qr_r[DW-1]};
  assign ge      = (trial >= {1'b0, den});
  assign rem_nxt = ge ? RNG_W'(trial - {1'b0, den}) : RNG_W'(trial);
  assign qr_nxt  = {qr_r[DW-2:0], ge};

  // The negative side of the error range reaches one step further.
  assign qmax      = neg ? DW'(ERR_POS + 1) : DW'(ERR_POS);
  assign qsat      = (qr_r > qmax) ? qmax : qr_r;
  assign neg_n_nxt = neg ? $signed((ERR_W+1)'(qsat)) : -$signed((ERR_W+1)'(qsat));

  assign acc = p1_r + PROD_W'(neg_n_r) * PROD_W'(COEF_NEW);

  always_comb begin
    f_nxt          = f_r;
    cc_nxt         = cc_r;
    lost_nxt       = lost_r;
    holding_nxt    = holding_r;
    hs_nxt         = hs_r;
    res_status_nxt = res_status_r;
    res_valid_nxt  = res_valid_r;
    res_yaw_nxt    = res_yaw_r;
    if (cmd.eval) begin
      res_status_nxt = STATUS_RUN;
      res_valid_nxt  = 1'b0;
      res_yaw_nxt    = '0;
      priority if (!func_r) begin
        f_nxt       = '0;
        cc_nxt      = '0;
        lost_nxt    = '0;
        holding_nxt = 1'b0;
        hs_nxt      = '0;
      end else if (!seen_r) begin
        lost_nxt       = lost_inc;
        res_status_nxt = (lost_inc > LW'(LOST_LIMIT)) ? STATUS_FAIL : STATUS_RUN;
        res_valid_nxt  = 1'b1;
        res_yaw_nxt    = clamp_lim(lost_base, lim_r);
      end else if (holding_r) begin
        lost_nxt       = '0;
        res_status_nxt = hold_done ? STATUS_OK : STATUS_RUN;
        res_valid_nxt  = 1'b1;
      end else begin
        lost_nxt = '0;
        cc_nxt   = centred ? cc_inc : 2'd0;
        if (confirm) begin
          holding_nxt = 1'b1;
          hs_nxt      = now_r;
        end
      end
    end
    if (cmd.filt_b) begin
      f_nxt = sat_err(round_q16(acc));
    end
    if (cmd.gain_b) begin
      res_status_nxt = STATUS_RUN;
      res_valid_nxt  = 1'b1;
      res_yaw_nxt    = clamp_lim(round_q16(p2_r), lim_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r     <= YAW_LIMIT_RST;
      hold_r    <= HOLD_TIME_RST;
      f_r       <= '0;
      cc_r      <= '0;
      lost_r    <= '0;
      holding_r <= 1'b0;
      hs_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_YAW_LIMIT: lim_r  <= cfg_wdata[LIM_W-1:0];
          CFG_HOLD_TIME: hold_r <= cfg_wdata[HOLD_W-1:0];
          default:       lim_r  <= lim_r;
        endcase
      end
      f_r       <= f_nxt;
      cc_r      <= cc_nxt;
      lost_r    <= lost_nxt;
      holding_r <= holding_nxt;
      hs_r      <= hs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      seen_r <= in_seen;
      off_r  <= in_offset_mm;
      rng_r  <= in_range_mm;
      now_r  <= in_now_ms;
    end
    if (cmd.eval) begin
      rem_r <= '0;
      qr_r  <= {mag, {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      qr_r  <= qr_nxt;
    end
    if (cmd.filt_a) begin
      neg_n_r <= neg_n_nxt;
      p1_r    <= PROD_W'(f_r) * PROD_W'(COEF_KEEP);
    end
    if (cmd.gain_a) begin
      p2_r <= PROD_W'(f_r) * PROD_W'(COEF_GAIN);
    end
    res_status_r <= res_status_nxt;
    res_valid_r  <= res_valid_nxt;
    res_yaw_r    <= res_yaw_nxt;
    if (cmd.load_out) begin
      out_status_r    <= res_status_r;
      out_cmd_valid_r <= res_valid_r;
      out_yaw_cmd_r   <= res_yaw_r;
    end
  end

  assign out_status    = out_status_r;
  assign out_cmd_valid = out_cmd_valid_r;
  assign out_yaw_cmd   = out_yaw_cmd_r;

endmodule
